@@ design/cgl_pkg.sv @@
package cgl_pkg;

   localparam int MAX_STOPS = 16;
   localparam int IDX_W     = $clog2(MAX_STOPS);
   localparam int CNT_W     = $clog2(MAX_STOPS + 1);
   localparam int FRAC_BITS = 15;
   localparam int ONE_Q     = 1 << FRAC_BITS;
   localparam int DEF_STOPS = (MAX_STOPS < 4) ? MAX_STOPS : 4;

   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_EDIT   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  stop_index;
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
      logic [15:0] position_in;
      logic [15:0] query_pos;
   } req_type;

   typedef struct packed {
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
      logic [15:0] pos_out;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] pos;
   } stop_type;

   // decoded request as it sits in the queue
   typedef struct packed {
      kind_type    op;
      logic [3:0]  stop_index;
      stop_type    stop;
      logic [15:0] query_pos;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   function automatic stop_type default_stop(input int k);
      stop_type s;
      logic [15:0] one;
      one = 16'(ONE_Q);
      unique case (k)
         0:       s = '{red: one,   green: one,   blue: one,   pos: 16'd0};
         1:       s = '{red: 16'd0, green: one,   blue: one,   pos: 16'((ONE_Q + 1) / 3)};
         2:       s = '{red: one,   green: 16'd0, blue: one,   pos: 16'((2 * ONE_Q + 1) / 3)};
         default: s = '{red: one,   green: one,   blue: 16'd0, pos: one};
      endcase
      return s;
   endfunction

endpackage

@@ design/cgl_front.sv @@
module cgl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  cgl_pkg::req_type   req_data,
   input  logic               pop,
   output cgl_pkg::qhead_type head
);
   import cgl_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   cmd_type    cmd;

   // classify the incoming request
   always_comb begin
      cmd.op         = kind_type'(req_data.kind);
      cmd.stop_index = req_data.stop_index;
      cmd.stop       = '{red: req_data.red_in, green: req_data.green_in,
                         blue: req_data.blue_in, pos: req_data.position_in};
      cmd.query_pos  = req_data.query_pos;
   end

   assign busy       = (fill_ff == 2'd2);
   assign push       = start && !busy;
   assign head.valid = (fill_ff != 2'd0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // hold queued requests
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

@@ design/cgl_div.sv @@
module cgl_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);
   import cgl_pkg::*;

   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic        fits;

   // one restoring step per cycle; the quotient is known to fit 16 bits
   assign trial = {rem_ff, quo_ff[15]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend[31:16];
         quo_in = dividend[15:0];
         den_in = divisor;
         cnt_in = 5'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? 16'(trial - {1'b0, den_ff}) : trial[15:0];
         quo_in = {quo_ff[14:0], fits};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/cgl_back.sv @@
module cgl_back (
   input  logic               clock,
   input  logic               reset,
   input  cgl_pkg::qhead_type head,
   output logic               pop,
   output logic               rsp_strobe,
   output cgl_pkg::rsp_type   rsp_data
);
   import cgl_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN1 = 7'b0000010,
      S_PICK  = 7'b0000100,
      S_SCAN2 = 7'b0001000,
      S_MUL   = 7'b0010000,
      S_SUM   = 7'b0100000,
      S_DIV   = 7'b1000000
   } state_type;

   stop_type    stop_ff [MAX_STOPS];
   logic [CNT_W-1:0] count_ff, count_in;
   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   stop_type    first_ff, first_in, last_ff, last_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0] lo_idx_ff, lo_idx_in;
   logic        lo_found_ff, lo_found_in, hi_found_ff, hi_found_in;
   logic [1:0]  ch_ff, ch_in;
   logic [31:0] prod0_ff, prod0_in, prod1_ff, prod1_in;
   rsp_type     rsp_ff, rsp_in;
   logic        strobe_ff, strobe_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   stop_type         wr_stop;
   stop_type         cur;
   logic             scan_end;
   logic [15:0]      t, c0, c1, num, den, q;
   logic [32:0]      sum;
   logic             div_start, div_done;
   logic             first_hit, last_hit, lo_hit, hi_hit;
   logic             first_scan;

   assign cur        = stop_ff[scan_ff];
   assign scan_end   = ({1'b0, scan_ff} == count_ff - CNT_W'(1));
   assign first_scan = (scan_ff == '0);
   assign t          = cmd_ff.query_pos;
   assign num        = t - lo_ff.pos;
   assign den        = hi_ff.pos - lo_ff.pos;
   assign sum        = {1'b0, prod0_ff} + {1'b0, prod1_ff} + {18'd0, den[15:1]};

   // select the channel being blended
   always_comb begin
      unique case (ch_ff)
         2'd0:    begin c0 = lo_ff.red;   c1 = hi_ff.red;   end
         2'd1:    begin c0 = lo_ff.green; c1 = hi_ff.green; end
         2'd2:    begin c0 = lo_ff.blue;  c1 = hi_ff.blue;  end
         default: begin c0 = lo_ff.pos;   c1 = hi_ff.pos;   end
      endcase
   end

   // neighbor search compares
   always_comb begin
      first_hit = first_scan || (cur.pos < first_ff.pos);
      last_hit  = first_scan || (cur.pos >= last_ff.pos);
      lo_hit    = (cur.pos <= t) && (first_scan || !lo_found_ff || cur.pos >= lo_ff.pos);
      hi_hit    = ((cur.pos > lo_ff.pos) || (cur.pos == lo_ff.pos && scan_ff > lo_idx_ff))
                  && (first_scan || !hi_found_ff || cur.pos < hi_ff.pos);
   end

   cgl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum),
      .divisor  (den),
      .done     (div_done),
      .quotient (q)
   );

   // sequence requests
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      cmd_in      = cmd_ff;
      scan_in     = scan_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      lo_idx_in   = lo_idx_ff;
      lo_found_in = lo_found_ff;
      hi_found_in = hi_found_ff;
      ch_in       = ch_ff;
      prod0_in    = prod0_ff;
      prod1_in    = prod1_ff;
      rsp_in      = rsp_ff;
      strobe_in   = 1'b0;
      pop         = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = head.cmd.stop_index[IDX_W-1:0];
      wr_stop     = head.cmd.stop;
      div_start   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               cmd_in = head.cmd;
               rsp_in = '0;
               unique case (head.cmd.op)
                  KIND_ADD: begin
                     strobe_in = 1'b1;
                     if (count_ff == CNT_W'(MAX_STOPS)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_EDIT: begin
                     strobe_in = 1'b1;
                     if (CNT_W'(head.cmd.stop_index) < count_ff) begin
                        wr_en = 1'b1;
                     end else begin
                        rsp_in.status = ST_BAD;
                     end
                  end
                  KIND_LOOKUP: begin
                     scan_in  = '0;
                     state_in = S_SCAN1;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN1: begin
            if (first_hit) first_in = cur;
            if (last_hit)  last_in  = cur;
            if (lo_hit) begin
               lo_in     = cur;
               lo_idx_in = scan_ff;
            end
            lo_found_in = lo_hit || (!first_scan && lo_found_ff);
            scan_in     = scan_ff + IDX_W'(1);
            if (scan_end) state_in = S_PICK;
         end
         S_PICK: begin
            // clamp to the ends, otherwise look for the upper neighbor
            if (t <= first_ff.pos || t >= last_ff.pos) begin
               if (t <= first_ff.pos) begin
                  rsp_in = '{first_ff.red, first_ff.green, first_ff.blue, first_ff.pos, ST_OK};
               end else begin
                  rsp_in = '{last_ff.red, last_ff.green, last_ff.blue, last_ff.pos, ST_OK};
               end
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               scan_in  = '0;
               state_in = S_SCAN2;
            end
         end
         S_SCAN2: begin
            if (hi_hit) hi_in = cur;
            hi_found_in = hi_hit || (!first_scan && hi_found_ff);
            scan_in     = scan_ff + IDX_W'(1);
            if (scan_end) begin
               ch_in    = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod0_in = c0 * (den - num);
            prod1_in = c1 * num;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (den == 16'd0) begin
               unique case (ch_ff)
                  2'd0:    rsp_in.red_out   = c1;
                  2'd1:    rsp_in.green_out = c1;
                  2'd2:    rsp_in.blue_out  = c1;
                  default: rsp_in.pos_out   = c1;
               endcase
               ch_in    = ch_ff + 2'd1;
               state_in = S_MUL;
               if (ch_ff == 2'd3) begin
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               unique case (ch_ff)
                  2'd0:    rsp_in.red_out   = q;
                  2'd1:    rsp_in.green_out = q;
                  2'd2:    rsp_in.blue_out  = q;
                  default: rsp_in.pos_out   = q;
               endcase
               ch_in    = ch_ff + 2'd1;
               state_in = S_MUL;
               if (ch_ff == 2'd3) begin
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= CNT_W'(DEF_STOPS);
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      scan_ff     <= scan_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      lo_idx_ff   <= lo_idx_in;
      lo_found_ff <= lo_found_in;
      hi_found_ff <= hi_found_in;
      ch_ff       <= ch_in;
      prod0_ff    <= prod0_in;
      prod1_ff    <= prod1_in;
      rsp_ff      <= rsp_in;
   end

   // stop table: default stops on reset, the rest loaded by requests
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEF_STOPS; k++) begin
            stop_ff[k] <= default_stop(k);
         end
      end else if (wr_en) begin
         stop_ff[wr_addr] <= wr_stop;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ design/colour_gradient_lookup_core.sv @@
// Colour gradient lookup over a table of up to 16 colour stops (Q1.15).
// A request is taken when start is high and busy is low; busy rises only
// when the two-entry request queue is full. Each request produces one
// response, shown for exactly one cycle with rsp_strobe, in request order;
// the receiver cannot stall it. Add, edit and unused kinds answer in the
// cycle after leaving the queue. A lookup scans the table once for the end
// stops and lower neighbor, then clamps to an end stop if the query lies at
// or outside the end stops; otherwise it scans again for the upper neighbor,
// then blends four channels in turn through one multiplier pair and one
// 16-step serial divider, which is skipped when both neighbors share a position.
module colour_gradient_lookup_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cgl_pkg::req_type req_data,
   output logic             rsp_strobe,
   output cgl_pkg::rsp_type rsp_data
);
   import cgl_pkg::*;

   qhead_type head;
   logic      pop;

   cgl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .pop      (pop),
      .head     (head)
   );

   cgl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // a flagged request carries no colour
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |->
      (rsp_data.red_out == 16'd0 && rsp_data.green_out == 16'd0 &&
       rsp_data.blue_out == 16'd0 && rsp_data.pos_out == 16'd0))
      else $error("flagged response with nonzero colour");

   // an accepted request is waiting in the queue on the next cycle
   a_push_seen: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> head.valid)
      else $error("accepted request missing from queue");
`endif

endmodule
